// ----- design/vtvc_pkg.sv -----
`default_nettype none

package vtvc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam int unsigned PAN_W  = 20;
  localparam int unsigned ZOOM_W = 24;
  localparam int unsigned HEXT_W = 17;
  localparam int unsigned DOC_W  = 16;
  localparam int unsigned TILE_W = 16;

  localparam int unsigned TILE_EDGE_W  = TILE_W + 2;
  localparam int unsigned NDIFF_W      = PAN_W + 1;
  localparam int unsigned NMAG_W       = PAN_W;
  localparam int unsigned DEN_W        = ZOOM_W + HEXT_W;
  localparam int unsigned MUL_STEPS    = DOC_W;
  localparam int unsigned EDGE_EXTRA_W = 36;
  localparam int unsigned NDC_ONE      = 65536;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PAN_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAN_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZOOM       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_EXT_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_EXT_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DOC_WIDTH  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DOC_HEIGHT = 3'd6;

  typedef struct packed {
    logic valid;
    logic empty;
  } vtvc_view_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vtvc_queue_status_t;

  typedef struct packed {
    logic                          empty;
    logic signed [TILE_EDGE_W-1:0] left;
    logic signed [TILE_EDGE_W-1:0] right;
    logic signed [TILE_EDGE_W-1:0] top;
    logic signed [TILE_EDGE_W-1:0] bottom;
  } vtvc_tile_t;

endpackage

`default_nettype wire

// ----- design/vtvc_view.sv -----
`default_nettype none

module vtvc_view import vtvc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0]                  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]                   cfg_data_i,
  output logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0]     view_l_o,
  output logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0]     view_r_o,
  output logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0]     view_t_o,
  output logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0]     view_b_o,
  output vtvc_view_status_t                            status_o
);

  localparam int unsigned EDGE_W  = FRAC_BITS + EDGE_EXTRA_W;
  localparam int unsigned SHIFT_N = 15 + FRAC_BITS;
  localparam int unsigned DVD_W   = NMAG_W + SHIFT_N;
  localparam int unsigned CNT_W   = $clog2(DVD_W);
  localparam int unsigned QM_W    = FRAC_BITS + 19;
  localparam int unsigned QS_W    = FRAC_BITS + 20;
  localparam int unsigned MCNT_W  = $clog2(MUL_STEPS);
  localparam int unsigned LIM_SH  = FRAC_BITS + 18;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ZH   = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_EDGE = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic              cfg_we;
  logic [PAN_W-1:0]  pan_x_q, pan_y_q;
  logic [ZOOM_W-1:0] zoom_q;
  logic [HEXT_W-1:0] hext_x_q, hext_y_q;
  logic [DOC_W-1:0]  doc_w_q, doc_h_q;

  logic [2:0]        state_q, state_d;
  logic [1:0]        sel_q, sel_d;
  logic              valid_q, valid_d;
  logic [DEN_W-1:0]  zh_q, zh_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [EDGE_W-1:0] mcand_q, mcand_d;
  logic [DOC_W-1:0]  mplier_q, mplier_d;
  logic [EDGE_W-1:0] acc_q, acc_d;
  logic [MCNT_W-1:0] mcnt_q, mcnt_d;
  logic [EDGE_W-1:0] edge_q [4];
  logic [EDGE_W-1:0] vl_q, vr_q, vt_q, vb_q;
  logic              empty_q;

  logic              x_side, pos_e;
  logic [PAN_W-1:0]  pan_sel;
  logic [HEXT_W-1:0] hext_sel, hext_eff;
  logic [ZOOM_W-1:0] zoom_eff;
  logic [DOC_W-1:0]  doc_sel;
  logic [NDIFF_W-1:0] ndc_e, n_diff, n_abs;
  logic              n_neg;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              rem_ge;
  logic [DVD_W:0]    qm_full;
  logic              q_sat;
  logic [QM_W-1:0]   q_mag;
  logic [QS_W-1:0]   q_sig;
  logic [EDGE_W-1:0] centre, edge_val;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_x_q  <= '0;
      pan_y_q  <= '0;
      zoom_q   <= ZOOM_W'(NDC_ONE);
      hext_x_q <= HEXT_W'(NDC_ONE);
      hext_y_q <= HEXT_W'(NDC_ONE);
      doc_w_q  <= '0;
      doc_h_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_PAN_X:      pan_x_q  <= cfg_data_i[PAN_W-1:0];
        REG_PAN_Y:      pan_y_q  <= cfg_data_i[PAN_W-1:0];
        REG_ZOOM:       zoom_q   <= cfg_data_i[ZOOM_W-1:0];
        REG_HALF_EXT_X: hext_x_q <= cfg_data_i[HEXT_W-1:0];
        REG_HALF_EXT_Y: hext_y_q <= cfg_data_i[HEXT_W-1:0];
        REG_DOC_WIDTH:  doc_w_q  <= cfg_data_i[DOC_W-1:0];
        REG_DOC_HEIGHT: doc_h_q  <= cfg_data_i[DOC_W-1:0];
        default: ;
      endcase
    end
  end

  // Edges 0 and 1 are left and right, edges 2 and 3 are top and bottom.
  assign x_side   = ~sel_q[1];
  assign pos_e    = (sel_q == 2'd1) || (sel_q == 2'd2);
  assign pan_sel  = x_side ? pan_x_q : pan_y_q;
  assign hext_sel = x_side ? hext_x_q : hext_y_q;
  assign doc_sel  = x_side ? doc_w_q : doc_h_q;
  assign zoom_eff = (zoom_q == '0) ? ZOOM_W'(1) : zoom_q;
  assign hext_eff = (hext_sel == '0) ? HEXT_W'(1) : hext_sel;

  assign ndc_e  = pos_e ? NDIFF_W'(NDC_ONE) : (NDIFF_W'(0) - NDIFF_W'(NDC_ONE));
  assign n_diff = ndc_e - {pan_sel[PAN_W-1], pan_sel};
  assign n_neg  = n_diff[NDIFF_W-1];
  assign n_abs  = n_neg ? (NDIFF_W'(0) - n_diff) : n_diff;

  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, zh_q};
  assign rem_sub = rem_sh - {1'b0, zh_q};

  assign qm_full = {1'b0, quo_q} + (DVD_W+1)'(neg_q && (rem_q != '0));
  assign q_sat   = qm_full > ((DVD_W+1)'(1) << LIM_SH);
  assign q_mag   = q_sat ? (QM_W'(1) << LIM_SH) : qm_full[QM_W-1:0];
  assign q_sig   = neg_q ? (QS_W'(0) - {1'b0, q_mag}) : {1'b0, q_mag};

  assign centre   = EDGE_W'(doc_sel) << (FRAC_BITS - 1);
  assign edge_val = x_side ? (centre + acc_q) : (centre - acc_q);

  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    valid_d  = valid_q;
    zh_d     = zh_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    mcnt_d   = mcnt_q;
    if (cfg_we) begin
      state_d = ST_ZH;
      sel_d   = 2'd0;
      valid_d = 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_ZH: begin
          zh_d    = DEN_W'(zoom_eff) * DEN_W'(hext_eff);
          rem_d   = '0;
          quo_d   = DVD_W'(n_abs[NMAG_W-1:0]) << SHIFT_N;
          neg_d   = n_neg;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_d = rem_sub[DEN_W-1:0];
          end else begin
            rem_d = rem_sh[DEN_W-1:0];
          end
          quo_d = {quo_q[DVD_W-2:0], rem_ge};
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DVD_W - 1)) begin
            state_d = ST_FIX;
          end
        end
        ST_FIX: begin
          mcand_d  = {{(EDGE_W-QS_W){q_sig[QS_W-1]}}, q_sig};
          mplier_d = doc_sel;
          acc_d    = '0;
          mcnt_d   = '0;
          state_d  = ST_MUL;
        end
        ST_MUL: begin
          acc_d    = acc_q + (mplier_q[0] ? mcand_q : '0);
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
          mcnt_d   = mcnt_q + MCNT_W'(1);
          if (mcnt_q == MCNT_W'(MUL_STEPS - 1)) begin
            state_d = ST_EDGE;
          end
        end
        ST_EDGE: begin
          if (sel_q == 2'd3) begin
            state_d = ST_DONE;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = ST_ZH;
          end
        end
        ST_DONE: begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ZH;
      sel_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zh_q     <= zh_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    mcnt_q   <= mcnt_d;
    if (state_q == ST_EDGE) begin
      edge_q[sel_q] <= edge_val;
    end
    if (state_q == ST_DONE) begin
      if ($signed(edge_q[0]) > $signed(edge_q[1])) begin
        vl_q <= edge_q[1];
        vr_q <= edge_q[0];
      end else begin
        vl_q <= edge_q[0];
        vr_q <= edge_q[1];
      end
      if ($signed(edge_q[2]) > $signed(edge_q[3])) begin
        vt_q <= edge_q[3];
        vb_q <= edge_q[2];
      end else begin
        vt_q <= edge_q[2];
        vb_q <= edge_q[3];
      end
      empty_q <= (edge_q[0] == edge_q[1]) || (edge_q[2] == edge_q[3]);
    end
  end

  assign view_l_o       = $signed(vl_q);
  assign view_r_o       = $signed(vr_q);
  assign view_t_o       = $signed(vt_q);
  assign view_b_o       = $signed(vb_q);
  assign status_o.valid = valid_q;
  assign status_o.empty = empty_q;

endmodule

`default_nettype wire

// ----- design/vtvc_front.sv -----
`default_nettype none

module vtvc_front import vtvc_pkg::*; (
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [TILE_W-1:0] tile_left_i,
  input  wire logic signed [TILE_W-1:0] tile_top_i,
  input  wire logic [TILE_W-1:0]        tile_width_i,
  input  wire logic [TILE_W-1:0]        tile_height_i,
  input  wire vtvc_view_status_t        view_status_i,
  input  wire vtvc_queue_status_t       queue_status_i,
  output logic                          push_o,
  output vtvc_tile_t                    tile_o
);

  logic [TILE_EDGE_W-1:0] left_ext, top_ext;

  assign in_ready_o = view_status_i.valid & ~queue_status_i.full;
  assign push_o     = in_valid_i & in_ready_o;

  assign left_ext = {{(TILE_EDGE_W-TILE_W){tile_left_i[TILE_W-1]}}, tile_left_i};
  assign top_ext  = {{(TILE_EDGE_W-TILE_W){tile_top_i[TILE_W-1]}}, tile_top_i};

  assign tile_o.empty  = (tile_width_i == '0) || (tile_height_i == '0);
  assign tile_o.left   = $signed(left_ext);
  assign tile_o.right  = $signed(left_ext + TILE_EDGE_W'(tile_width_i));
  assign tile_o.top    = $signed(top_ext);
  assign tile_o.bottom = $signed(top_ext + TILE_EDGE_W'(tile_height_i));

endmodule

`default_nettype wire

// ----- design/vtvc_queue.sv -----
`default_nettype none

module vtvc_queue import vtvc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire vtvc_tile_t   data_i,
  input  wire logic         pop_i,
  output vtvc_tile_t        data_o,
  output vtvc_queue_status_t status_o
);

  localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

  vtvc_tile_t         slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [COUNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wptr_d  = push_i ? ptr_next(wptr_q) : wptr_q;
    rptr_d  = pop_i ? ptr_next(rptr_q) : rptr_q;
    count_d = count_q + COUNT_W'(push_i) - COUNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign data_o         = slot_q[rptr_q];
  assign status_o.full  = (count_q == COUNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ----- design/vtvc_back.sv -----
`default_nettype none

module vtvc_back import vtvc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire vtvc_tile_t                               tile_i,
  input  wire vtvc_queue_status_t                       queue_status_i,
  output logic                                          pop_o,
  input  wire logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0] view_l_i,
  input  wire logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0] view_r_i,
  input  wire logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0] view_t_i,
  input  wire logic signed [FRAC_BITS+EDGE_EXTRA_W-1:0] view_b_i,
  input  wire vtvc_view_status_t                        view_status_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_ready_i,
  output logic                                          tile_visible_o
);

  localparam int unsigned EDGE_W = FRAC_BITS + EDGE_EXTRA_W;
  localparam int unsigned EXT_W  = EDGE_W - TILE_EDGE_W;

  logic              out_valid_q, out_valid_d;
  logic              visible_q, visible_d;
  logic [EDGE_W-1:0] al, ar, at, ab;
  logic              overlap;

  assign al = {{EXT_W{tile_i.left[TILE_EDGE_W-1]}}, tile_i.left} << FRAC_BITS;
  assign ar = {{EXT_W{tile_i.right[TILE_EDGE_W-1]}}, tile_i.right} << FRAC_BITS;
  assign at = {{EXT_W{tile_i.top[TILE_EDGE_W-1]}}, tile_i.top} << FRAC_BITS;
  assign ab = {{EXT_W{tile_i.bottom[TILE_EDGE_W-1]}}, tile_i.bottom} << FRAC_BITS;

  assign overlap = (view_l_i < $signed(ar)) && ($signed(al) < view_r_i) &&
                   (view_t_i < $signed(ab)) && ($signed(at) < view_b_i);

  assign pop_o = ~queue_status_i.empty & (~out_valid_q | out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    visible_d   = visible_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      visible_d   = overlap & ~tile_i.empty & ~view_status_i.empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q <= visible_d;
  end

  assign out_valid_o    = out_valid_q;
  assign tile_visible_o = visible_q;

endmodule

`default_nettype wire

// ----- design/viewport_tile_visibility_cull.sv -----
// Each accepted word is written into the queue and its result registered in the back stage.
// Throughput: one word per cycle while the output is ready, set by the back-stage compare.
// After reset and after every configuration write the four view edges are recomputed in turn
// by a shared serial divider and shift-add multiplier; no word is accepted in the meantime.
// Reset is asynchronous and active low; only the control and config registers are reset.
`default_nettype none

module viewport_tile_visibility_cull import vtvc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [TILE_W-1:0] tile_left_i,
  input  wire logic signed [TILE_W-1:0] tile_top_i,
  input  wire logic [TILE_W-1:0]        tile_width_i,
  input  wire logic [TILE_W-1:0]        tile_height_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          tile_visible_o
);

  localparam int unsigned EDGE_W = FRAC_BITS + EDGE_EXTRA_W;

  logic signed [EDGE_W-1:0] view_l, view_r, view_t, view_b;
  vtvc_view_status_t        view_status;
  vtvc_queue_status_t       queue_status;
  vtvc_tile_t               push_tile, head_tile;
  logic                     push, pop;

  vtvc_view #(.FRAC_BITS(FRAC_BITS)) u_view (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .view_l_o    (view_l),
    .view_r_o    (view_r),
    .view_t_o    (view_t),
    .view_b_o    (view_b),
    .status_o    (view_status)
  );

  vtvc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tile_left_i    (tile_left_i),
    .tile_top_i     (tile_top_i),
    .tile_width_i   (tile_width_i),
    .tile_height_i  (tile_height_i),
    .view_status_i  (view_status),
    .queue_status_i (queue_status),
    .push_o         (push),
    .tile_o         (push_tile)
  );

  vtvc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_tile),
    .pop_i    (pop),
    .data_o   (head_tile),
    .status_o (queue_status)
  );

  vtvc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tile_i         (head_tile),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .view_l_i       (view_l),
    .view_r_i       (view_r),
    .view_t_i       (view_t),
    .view_b_i       (view_b),
    .view_status_i  (view_status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tile_visible_o (tile_visible_o)
  );

endmodule

`default_nettype wire

// ----- design/vtvc_checker.sv -----
`default_nettype none

module vtvc_port_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic cfg_valid_i,
  input wire logic cfg_ready_o,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic tile_visible_o
);

  logic [2:0] pending_q, pending_d;
  logic       in_take, out_take;

  assign in_take   = in_valid_i & in_ready_o;
  assign out_take  = out_valid_o & out_ready_i;
  assign pending_d = pending_q + 3'(in_take) - 3'(out_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("input accepted right after a configuration write");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tile_visible_o))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result shown with no word outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more words outstanding than the block can hold");

endmodule

bind viewport_tile_visibility_cull vtvc_port_checker u_checker (.*);

`default_nettype wire

// ----- tb/vtvc_checker.sv -----
module vtvc_checker import vtvc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_i,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic signed [TILE_W-1:0] tile_left_i,
  input  wire logic signed [TILE_W-1:0] tile_top_i,
  input  wire logic [TILE_W-1:0]        tile_width_i,
  input  wire logic [TILE_W-1:0]        tile_height_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic                     tile_visible_i,
  output int                            mismatch_count_o,
  output int                            pending_o,
  output int                            visible_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_PX   = longint'(1) << FRAC_BITS_DEF;
  localparam longint Q_SAT    = longint'(1) << (FRAC_BITS_DEF + 18);
  localparam longint NDC_UNIT = longint'(NDC_ONE);

  typedef struct {
    logic signed [TILE_W-1:0] left;
    logic signed [TILE_W-1:0] top;
    logic [TILE_W-1:0]        width;
    logic [TILE_W-1:0]        height;
    bit                       visible;
  } tile_verdict_t;

  logic signed [PAN_W-1:0] pan_x_cfg;
  logic signed [PAN_W-1:0] pan_y_cfg;
  logic [ZOOM_W-1:0]       zoom_cfg;
  logic [HEXT_W-1:0]       half_x_cfg;
  logic [HEXT_W-1:0]       half_y_cfg;
  logic [DOC_W-1:0]        doc_w_cfg;
  logic [DOC_W-1:0]        doc_h_cfg;

  tile_verdict_t verdict_q[$];
  int            mismatches;
  int            visible_seen;

  function automatic longint floor_quot(longint num, longint den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  // Offset of one NDC side from the document center, in units of the document size.
  function automatic longint view_offset(longint ndc_side, longint pan, longint den);
    longint q;
    q = floor_quot((ndc_side - pan) * (longint'(1) << (15 + FRAC_BITS_DEF)), den);
    if (q > Q_SAT) begin
      q = Q_SAT;
    end
    if (q < -Q_SAT) begin
      q = -Q_SAT;
    end
    return q;
  endfunction

  function automatic bit tile_in_view(longint left, longint top, longint width,
                                      longint height);
    longint dw, dh, zm, hx, hy, cx, cy, vl, vr, vt, vb, swap;
    dw = doc_w_cfg;
    dh = doc_h_cfg;
    if (dw == 0 || dh == 0 || width == 0 || height == 0) begin
      return 1'b0;
    end
    zm = (zoom_cfg == '0) ? 1 : zoom_cfg;
    hx = (half_x_cfg == '0) ? 1 : half_x_cfg;
    hy = (half_y_cfg == '0) ? 1 : half_y_cfg;
    cx = dw * (longint'(1) << (FRAC_BITS_DEF - 1));
    cy = dh * (longint'(1) << (FRAC_BITS_DEF - 1));
    vl = cx + view_offset(-NDC_UNIT, longint'(pan_x_cfg), zm * hx) * dw;
    vr = cx + view_offset(NDC_UNIT, longint'(pan_x_cfg), zm * hx) * dw;
    vt = cy - view_offset(NDC_UNIT, longint'(pan_y_cfg), zm * hy) * dh;
    vb = cy - view_offset(-NDC_UNIT, longint'(pan_y_cfg), zm * hy) * dh;
    if (vl > vr) begin
      swap = vl;
      vl = vr;
      vr = swap;
    end
    if (vt > vb) begin
      swap = vt;
      vt = vb;
      vb = swap;
    end
    return vl != vr && vt != vb &&
           vl < (left + width) * ONE_PX && left * ONE_PX < vr &&
           vt < (top + height) * ONE_PX && top * ONE_PX < vb;
  endfunction

  function automatic void flag_mismatch(string what);
    if (mismatches < 10) begin
      $display("[%0t] tile visibility mismatch: %s", $realtime, what);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tile_verdict_t word;
    if (!rst_ni) begin
      pan_x_cfg  = '0;
      pan_y_cfg  = '0;
      zoom_cfg   = ZOOM_W'(NDC_ONE);
      half_x_cfg = HEXT_W'(NDC_ONE);
      half_y_cfg = HEXT_W'(NDC_ONE);
      doc_w_cfg  = '0;
      doc_h_cfg  = '0;
      verdict_q.delete();
      mismatches   = 0;
      visible_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PAN_X: begin
            pan_x_cfg = cfg_data_i[PAN_W-1:0];
          end
          REG_PAN_Y: begin
            pan_y_cfg = cfg_data_i[PAN_W-1:0];
          end
          REG_ZOOM: begin
            zoom_cfg = cfg_data_i[ZOOM_W-1:0];
          end
          REG_HALF_EXT_X: begin
            half_x_cfg = cfg_data_i[HEXT_W-1:0];
          end
          REG_HALF_EXT_Y: begin
            half_y_cfg = cfg_data_i[HEXT_W-1:0];
          end
          REG_DOC_WIDTH: begin
            doc_w_cfg = cfg_data_i[DOC_W-1:0];
          end
          REG_DOC_HEIGHT: begin
            doc_h_cfg = cfg_data_i[DOC_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("result %b with no tile waiting", tile_visible_i));
        end else begin
          word = verdict_q.pop_front();
          if (tile_visible_i !== word.visible) begin
            flag_mismatch($sformatf("tile l=%0d t=%0d w=%0d h=%0d expected %b got %b",
                                    word.left, word.top, word.width, word.height,
                                    word.visible, tile_visible_i));
          end
          if (tile_visible_i === 1'b1) begin
            visible_seen++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        word.left    = tile_left_i;
        word.top     = tile_top_i;
        word.width   = tile_width_i;
        word.height  = tile_height_i;
        word.visible = tile_in_view(longint'(tile_left_i), longint'(tile_top_i),
                                    longint'(tile_width_i), longint'(tile_height_i));
        verdict_q.push_back(word);
      end
    end
    pending_o        <= verdict_q.size();
    mismatch_count_o <= mismatches;
    visible_count_o  <= visible_seen;
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vtvc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TILE_TARGET = 1650;
  localparam int LONG_HOLD   = 400;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_INDEX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i    = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic signed [TILE_W-1:0] tile_left_i   = '0;
  logic signed [TILE_W-1:0] tile_top_i    = '0;
  logic [TILE_W-1:0]        tile_width_i  = '0;
  logic [TILE_W-1:0]        tile_height_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic                     tile_visible_o;

  int mismatch_count;
  int tiles_in_flight;
  int visible_count;
  int tiles_sent    = 0;
  int views_applied = 0;
  int cycle_count   = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int ready_left    = 0;
  int phase;
  bit burst_mode    = 1'b0;
  bit sink_busy     = 1'b0;

  viewport_tile_visibility_cull DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tile_left_i    (tile_left_i),
    .tile_top_i     (tile_top_i),
    .tile_width_i   (tile_width_i),
    .tile_height_i  (tile_height_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tile_visible_o (tile_visible_o)
  );

  vtvc_checker cull_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .tile_left_i      (tile_left_i),
    .tile_top_i       (tile_top_i),
    .tile_width_i     (tile_width_i),
    .tile_height_i    (tile_height_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tile_visible_i   (tile_visible_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (tiles_in_flight),
    .visible_count_o  (visible_count)
  );

  always #6ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, tiles_in_flight);
      $display("** viewport_tile_visibility_cull: FAILED **");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end
    if (r < 92) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (burst_mode || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return idle_len();
  endfunction

  // The output side stalls on its own; a requested hold keeps it stalled for a long stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        sink_busy  = !burst_mode && ($urandom_range(0, 99) < 35);
        ready_left = sink_busy ? idle_len() : $urandom_range(1, 40);
      end
      ready_left--;
      out_ready_i <= !sink_busy;
    end
  end

  function automatic logic [CFG_DATA_W-1:0] pick_pan();
    int r;
    logic [PAN_W-1:0] pan;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      pan = {1'b1, {(PAN_W-1){1'b0}}};
    end else if (r < 16) begin
      pan = {1'b0, {(PAN_W-1){1'b1}}};
    end else if (r < 65) begin
      pan = PAN_W'($urandom_range(0, 131072) - 65536);
    end else begin
      pan = PAN_W'($urandom);
    end
    return {(CFG_DATA_W-PAN_W)'($urandom), pan};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_half();
    int r;
    logic [HEXT_W-1:0] half;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      half = '0;
    end else if (r < 10) begin
      half = HEXT_W'(1);
    end else if (r < 15) begin
      half = HEXT_W'(NDC_ONE);
    end else if (r < 20) begin
      half = '1;
    end else if (r < 25) begin
      half = HEXT_W'($urandom);
    end else begin
      half = HEXT_W'($urandom_range(16384, 65536));
    end
    return {(CFG_DATA_W-HEXT_W)'($urandom), half};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_doc();
    int r;
    logic [DOC_W-1:0] size;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      size = '0;
    end else if (r < 10) begin
      size = DOC_W'(1);
    end else if (r < 14) begin
      size = '1;
    end else begin
      size = DOC_W'($urandom_range(16, 2048));
    end
    return {(CFG_DATA_W-DOC_W)'($urandom), size};
  endfunction

  task automatic send_tile(logic [TILE_W-1:0] left, logic [TILE_W-1:0] top,
                           logic [TILE_W-1:0] width, logic [TILE_W-1:0] height);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    tile_left_i   <= left;
    tile_top_i    <= top;
    tile_width_i  <= width;
    tile_height_i <= height;
    do @(posedge clk_i); while (!in_ready_o);
    tiles_sent++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_view(logic [CFG_DATA_W-1:0] pan_x, logic [CFG_DATA_W-1:0] pan_y,
                            logic [CFG_DATA_W-1:0] zoom, logic [CFG_DATA_W-1:0] half_x,
                            logic [CFG_DATA_W-1:0] half_y, logic [CFG_DATA_W-1:0] doc_w,
                            logic [CFG_DATA_W-1:0] doc_h);
    write_reg(REG_PAN_X, pan_x);
    write_reg(REG_PAN_Y, pan_y);
    write_reg(REG_ZOOM, zoom);
    write_reg(REG_HALF_EXT_X, half_x);
    write_reg(REG_HALF_EXT_Y, half_y);
    write_reg(REG_DOC_WIDTH, doc_w);
    write_reg(REG_DOC_HEIGHT, doc_h);
    cfg_valid_i <= 1'b0;
    views_applied++;
  endtask

  task automatic drain_tiles();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tiles_in_flight != 0);
  endtask

  task automatic run_random_phase(int n_tiles, bit with_hold);
    logic [CFG_DATA_W-1:0] zoom_d;
    logic [CFG_DATA_W-1:0] doc_w_d;
    logic [CFG_DATA_W-1:0] doc_h_d;
    int dw, dh, r, l, t, w, h;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      zoom_d = '0;
    end else if (r < 10) begin
      zoom_d = CFG_DATA_W'(1);
    end else if (r < 15) begin
      zoom_d = '1;
    end else if (r < 20) begin
      zoom_d = CFG_DATA_W'($urandom);
    end else begin
      zoom_d = CFG_DATA_W'($urandom_range(16384, 262144));
    end
    doc_w_d = pick_doc();
    doc_h_d = pick_doc();
    dw = doc_w_d[DOC_W-1:0];
    dh = doc_h_d[DOC_W-1:0];
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    end
    apply_view(pick_pan(), pick_pan(), zoom_d, pick_half(), pick_half(), doc_w_d, doc_h_d);
    for (int i = 0; i < n_tiles; i++) begin
      if (with_hold && i == 6) begin
        hold_requests++;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        l = $urandom;
        t = $urandom;
        w = $urandom;
        h = $urandom;
      end else if (r < 35) begin
        l = dw / 2 + $urandom_range(0, 256) - 128;
        t = dh / 2 + $urandom_range(0, 256) - 128;
        w = $urandom_range(0, 64);
        h = $urandom_range(0, 64);
      end else begin
        l = $urandom_range(0, 3 * dw + 2) - (dw + 1);
        t = $urandom_range(0, 3 * dh + 2) - (dh + 1);
        w = $urandom_range(0, dw + 1);
        h = $urandom_range(0, dh + 1);
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        w = 0;
      end else if (r < 8) begin
        h = 0;
      end
      send_tile(TILE_W'(l), TILE_W'(t), TILE_W'(w), TILE_W'(h));
    end
    drain_tiles();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset settings there is no document, so nothing is visible.
    send_tile(16'd0, 16'd0, 16'd10, 16'd10);
    send_tile(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    drain_tiles();

    // A plain view shows exactly the 1000 by 800 document.
    apply_view(24'd0, 24'd0, 24'd65536, 24'd65536, 24'd65536, 24'd1000, 24'd800);
    send_tile(16'd0, 16'd0, 16'd1000, 16'd800);
    send_tile(TILE_W'(-5), 16'd0, 16'd5, 16'd10);
    send_tile(TILE_W'(-5), 16'd0, 16'd6, 16'd10);
    send_tile(16'd1000, 16'd10, 16'd5, 16'd5);
    send_tile(16'd999, 16'd10, 16'd5, 16'd5);
    send_tile(16'd10, TILE_W'(-5), 16'd5, 16'd5);
    send_tile(16'd10, 16'd800, 16'd5, 16'd5);
    send_tile(16'd10, 16'd799, 16'd5, 16'd5);
    send_tile(16'd100, 16'd100, 16'd0, 16'd10);
    send_tile(16'd100, 16'd100, 16'd10, 16'd0);
    send_tile(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_tile(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_tile(16'h8000, 16'h8000, 16'd1, 16'd1);
    send_tile(16'd500, 16'd400, 16'd1, 16'd1);
    drain_tiles();

    // Panned far off with the smallest scale: both sides saturate and the view is empty.
    apply_view(24'h07FFFF, 24'd0, 24'd1, 24'd1, 24'd1, 24'd1000, 24'd800);
    send_tile(16'd0, 16'd0, 16'd1000, 16'd800);
    send_tile(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    drain_tiles();

    apply_view(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd1);
    send_tile(16'd0, 16'd0, 16'd1, 16'd1);
    send_tile(16'h7FFF, 16'h7FFF, 16'd1, 16'd1);
    drain_tiles();

    write_reg(REG_UNUSED, 24'hFFFFFF);
    apply_view(24'd0, 24'h080000, 24'hFFFFFF, 24'h01FFFF, 24'h01FFFF, 24'd1000, 24'd800);
    send_tile(16'd0, 16'd0, 16'd1000, 16'd800);
    send_tile(16'd500, 16'd400, 16'd1, 16'd1);
    drain_tiles();

    phase = 0;
    while (tiles_sent < TILE_TARGET) begin
      burst_mode = (phase % 5 == 2) || phase == 1 || phase == 7;
      run_random_phase($urandom_range(60, 140), phase == 1 || phase == 7);
      phase++;
    end
    burst_mode = 1'b0;

    repeat (8) @(posedge clk_i);
    $display("Sent %0d tile words under %0d view settings; %0d came back visible.",
             tiles_sent, views_applied, visible_count);
    $display("Views ranged over empty documents, saturated and empty views, zero and");
    $display("oversize scale registers, with random gaps, bursts and long output stalls.");
    if (mismatch_count == 0 && tiles_in_flight == 0) begin
      $display("** viewport_tile_visibility_cull: PASSED **");
    end else begin
      $display("** viewport_tile_visibility_cull: FAILED **");
    end
    $finish;
  end

endmodule
